// File: hw/rtl/atfr_pkg.sv
// ----------------------------------------------------------------------------
// ADTS to FLV repacker package
// Shared types, codes and constants for the ADTS to FLV audio tag repacker.
// ----------------------------------------------------------------------------
package atfr_pkg;

  localparam int unsigned FRAME_LEN_BITS = 13;
  localparam int unsigned QDEPTH         = 4;
  localparam int unsigned QPTR_W         = $clog2(QDEPTH);
  localparam int unsigned QCNT_W         = QPTR_W + 1;

  localparam logic [3:0] FMT_AAC       = 4'd10;
  localparam logic [7:0] SYNC_BYTE     = 8'hff;
  localparam logic [3:0] SYNC_NIBBLE   = 4'hf;
  localparam logic [3:0] HSIZE_NO_CRC  = 4'd7;
  localparam logic [3:0] HSIZE_CRC     = 4'd9;
  localparam logic [1:0] PROFILE_BAD   = 2'd3;
  localparam logic [3:0] SFI_BAD       = 4'hf;
  localparam logic [3:0] SFI_11025     = 4'd10;
  localparam logic [3:0] SFI_22050     = 4'd7;
  localparam logic [3:0] SFI_44100     = 4'd4;
  localparam logic [7:0] PKT_SEQ_HDR   = 8'h00;
  localparam logic [7:0] PKT_RAW       = 8'h01;

  typedef enum logic [1:0] {
    CFG_FORMAT = 2'd0,
    CFG_RATE   = 2'd1,
    CFG_SIZE   = 2'd2,
    CFG_TYPE   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RATE_5512  = 2'd0,
    RATE_11025 = 2'd1,
    RATE_22050 = 2'd2,
    RATE_44100 = 2'd3
  } rate_e;

  typedef enum logic [1:0] {
    KIND_SEQ  = 2'd0,
    KIND_RAW  = 2'd1,
    KIND_PASS = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_TRUNC = 2'd1,
    ERR_SYNC  = 2'd2,
    ERR_CFG   = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    OP_PASS_HDR = 3'd0,
    OP_DATA     = 3'd1,
    OP_DATA_ERR = 3'd2,
    OP_ERR      = 3'd3,
    OP_FRAME    = 3'd4
  } op_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in_buffer;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] tag_kind;
    logic       tag_first;
    logic       tag_last;
    logic [1:0] error_code;
  } out_item_t;

  typedef struct packed {
    logic [3:0] format_code;
    logic [1:0] rate_code;
    logic       sample_size;
    logic       channel_mode;
  } cfg_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    kind_e      kind;
    logic       last;
    err_e       err;
    logic       seq;
    logic [7:0] asc0;
    logic [7:0] asc1;
  } cmd_t;

endpackage

// File: hw/rtl/atfr_front.sv
// ----------------------------------------------------------------------------
// ADTS parser front end
// Accepts input bytes, tracks the ADTS header and payload, and turns each
// byte into at most one command for the tag builder.
// ----------------------------------------------------------------------------
module atfr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  atfr_pkg::cfg_t    cfg_i,
  input  logic              accept_i,
  input  atfr_pkg::in_item_t in_i,
  output logic              push_o,
  output atfr_pkg::cmd_t    cmd_o
);
  import atfr_pkg::*;

  typedef enum logic [3:0] {
    PH_BUF  = 4'b0001,
    PH_HDR  = 4'b0010,
    PH_PAY  = 4'b0100,
    PH_PASS = 4'b1000
  } phase_e;

  phase_e                    phase_q, phase_d;
  logic   [3:0]              cnt_q, cnt_d;
  logic   [1:0]              prof_q, prof_d;
  logic   [3:0]              sfi_q, sfi_d;
  logic   [2:0]              chan_q, chan_d;
  logic                      crc_q, crc_d;
  logic   [FRAME_LEN_BITS-1:0] flen_q, flen_d;
  logic   [FRAME_LEN_BITS-1:0] left_q, left_d;
  logic                      seq_q, seq_d;
  logic                      drop_q, drop_d;

  logic   [7:0]              b;
  logic                      last;
  logic   [3:0]              cnt_eff;
  logic   [3:0]              cnt_inc;
  logic   [3:0]              hsize;
  logic   [FRAME_LEN_BITS-1:0] pl;
  logic   [FRAME_LEN_BITS-1:0] left_dec;
  logic   [3:0]              sfi_ovr;
  logic                      sync_bad;
  logic                      fail_en;
  err_e                      fail_code;

  assign b        = in_i.data_byte;
  assign last     = in_i.last_in_buffer;
  assign cnt_eff  = (phase_q == PH_BUF) ? 4'd0 : cnt_q;
  assign cnt_inc  = cnt_eff + 4'd1;
  assign hsize    = crc_d ? HSIZE_CRC : HSIZE_NO_CRC;
  assign pl       = flen_d - {{(FRAME_LEN_BITS-4){1'b0}}, hsize};
  assign left_dec = left_q - {{(FRAME_LEN_BITS-1){1'b0}}, 1'b1};
  assign sync_bad = ((cnt_eff == 4'd0) && (b != SYNC_BYTE)) ||
                    ((cnt_eff == 4'd1) && (b[7:4] != SYNC_NIBBLE));

  always_comb begin
    case (cfg_i.rate_code)
      RATE_11025: sfi_ovr = SFI_11025;
      RATE_22050: sfi_ovr = SFI_22050;
      RATE_44100: sfi_ovr = SFI_44100;
      default:    sfi_ovr = sfi_d;
    endcase
  end

  always_comb begin
    prof_d = prof_q;
    sfi_d  = sfi_q;
    chan_d = chan_q;
    crc_d  = crc_q;
    flen_d = flen_q;
    case (cnt_eff)
      4'd1: crc_d = ~b[0];
      4'd2: begin
        prof_d = b[7:6];
        sfi_d  = b[5:2];
        chan_d = {b[0], 2'b00};
      end
      4'd3: begin
        chan_d = {chan_q[2], b[7:6]};
        flen_d = {b[1:0], {(FRAME_LEN_BITS-2){1'b0}}};
      end
      4'd4: flen_d = {flen_q[FRAME_LEN_BITS-1:FRAME_LEN_BITS-2], b, 3'b000};
      4'd5: flen_d = {flen_q[FRAME_LEN_BITS-1:3], b[7:5]};
      default: ;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    left_d    = left_q;
    seq_d     = seq_q;
    drop_d    = drop_q;
    push_o    = 1'b0;
    fail_en   = 1'b0;
    fail_code = ERR_NONE;
    cmd_o     = '0;
    cmd_o.data = b;
    cmd_o.last = last;
    cmd_o.asc0 = {3'b000, prof_d + 2'd1, sfi_ovr[3:1]};
    cmd_o.asc1 = {sfi_ovr[0], 1'b0, chan_d, 3'b000};
    if (accept_i) begin
      if (drop_q) begin
        if (last) begin
          drop_d  = 1'b0;
          phase_d = PH_BUF;
          cnt_d   = 4'd0;
        end
      end else if ((phase_q == PH_BUF) && (cfg_i.format_code != FMT_AAC)) begin
        push_o     = 1'b1;
        cmd_o.op   = OP_PASS_HDR;
        cmd_o.kind = KIND_PASS;
        phase_d    = last ? PH_BUF : PH_PASS;
      end else if (phase_q == PH_PASS) begin
        push_o     = 1'b1;
        cmd_o.op   = OP_DATA;
        cmd_o.kind = KIND_PASS;
        if (last) begin
          phase_d = PH_BUF;
        end
      end else if (phase_q == PH_PAY) begin
        push_o     = 1'b1;
        cmd_o.kind = KIND_RAW;
        left_d     = left_dec;
        if (left_dec == '0) begin
          cmd_o.op   = OP_DATA;
          cmd_o.last = 1'b1;
          cnt_d      = 4'd0;
          phase_d    = last ? PH_BUF : PH_HDR;
        end else if (last) begin
          cmd_o.op  = OP_DATA_ERR;
          cmd_o.err = ERR_TRUNC;
          cnt_d     = 4'd0;
          phase_d   = PH_BUF;
        end else begin
          cmd_o.op = OP_DATA;
        end
      end else begin
        phase_d = PH_HDR;
        if (sync_bad) begin
          fail_en   = 1'b1;
          fail_code = ERR_SYNC;
        end else if (cnt_inc < hsize) begin
          cnt_d = cnt_inc;
          if (last) begin
            fail_en   = 1'b1;
            fail_code = ERR_TRUNC;
          end
        end else if (flen_d < {{(FRAME_LEN_BITS-4){1'b0}}, hsize}) begin
          fail_en   = 1'b1;
          fail_code = ERR_TRUNC;
        end else if (last && (pl != '0)) begin
          fail_en   = 1'b1;
          fail_code = ERR_TRUNC;
        end else if (!seq_q && (prof_d == PROFILE_BAD)) begin
          fail_en   = 1'b1;
          fail_code = ERR_CFG;
        end else if (!seq_q && (sfi_ovr == SFI_BAD)) begin
          fail_en   = 1'b1;
          fail_code = ERR_CFG;
        end else begin
          push_o     = 1'b1;
          cmd_o.op   = OP_FRAME;
          cmd_o.kind = KIND_RAW;
          cmd_o.seq  = ~seq_q;
          cmd_o.last = (pl == '0);
          seq_d      = 1'b1;
          cnt_d      = 4'd0;
          if (pl == '0) begin
            phase_d = last ? PH_BUF : PH_HDR;
          end else begin
            left_d  = pl;
            phase_d = PH_PAY;
          end
        end
      end
      if (fail_en) begin
        push_o     = 1'b1;
        cmd_o.op   = OP_ERR;
        cmd_o.kind = KIND_RAW;
        cmd_o.err  = fail_code;
        cnt_d      = 4'd0;
        phase_d    = PH_BUF;
        drop_d     = ~last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BUF;
      cnt_q   <= '0;
      prof_q  <= '0;
      sfi_q   <= '0;
      chan_q  <= '0;
      crc_q   <= 1'b0;
      flen_q  <= '0;
      left_q  <= '0;
      seq_q   <= 1'b0;
      drop_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      prof_q  <= prof_d;
      sfi_q   <= sfi_d;
      chan_q  <= chan_d;
      crc_q   <= crc_d;
      flen_q  <= flen_d;
      left_q  <= left_d;
      seq_q   <= seq_d;
      drop_q  <= drop_d;
    end
  end

`ifndef SYNTH
  // Once the sequence header has gone out it is never sent again.
  assert property (@(posedge clk_i) disable iff (!rst_ni) seq_q |=> seq_q)
    else $error("sequence header flag cleared");
  // A header count never runs past the longest ADTS header.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q < HSIZE_CRC)
    else $error("header byte count out of range");
`endif

endmodule

// File: hw/rtl/atfr_fifo.sv
// ----------------------------------------------------------------------------
// Command queue
// Short queue of parsed commands between the parser and the tag builder.
// ----------------------------------------------------------------------------
module atfr_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  atfr_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output atfr_pkg::cmd_t pop_data_o
);
  import atfr_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o     = (count_q == QCNT_W'(QDEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QPTR_W'(1);
      end
      count_q <= count_d;
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into a full command queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("pop from an empty command queue");
`endif

endmodule

// File: hw/rtl/atfr_back.sv
// ----------------------------------------------------------------------------
// FLV tag builder
// Expands each queued command into tag body bytes, one per cycle while the
// output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module atfr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  atfr_pkg::cfg_t      cfg_i,
  input  logic                cmd_valid_i,
  input  atfr_pkg::cmd_t      cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output atfr_pkg::out_item_t out_o
);
  import atfr_pkg::*;

  logic [2:0] idx_q;
  logic [2:0] eff;
  logic [2:0] end_idx;
  logic       advance;
  logic [7:0] hdr_aac;
  logic [7:0] hdr_pass;
  logic       out_valid_q;
  out_item_t  out_q;
  out_item_t  item;

  assign hdr_aac  = {FMT_AAC, cfg_i.rate_code, cfg_i.sample_size, cfg_i.channel_mode};
  assign hdr_pass = {cfg_i.format_code, cfg_i.rate_code, cfg_i.sample_size,
                     cfg_i.channel_mode};
  assign eff      = idx_q | {(cmd_i.op == OP_FRAME) && !cmd_i.seq, 2'b00};
  assign advance  = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o    = advance && (eff == end_idx);

  always_comb begin
    case (cmd_i.op)
      OP_PASS_HDR: end_idx = 3'd1;
      OP_DATA_ERR: end_idx = 3'd1;
      OP_FRAME:    end_idx = 3'd5;
      default:     end_idx = 3'd0;
    endcase
  end

  always_comb begin
    item            = '0;
    item.tag_kind   = cmd_i.kind;
    item.error_code = ERR_NONE;
    case (cmd_i.op)
      OP_PASS_HDR: begin
        if (eff == 3'd0) begin
          item.out_byte  = hdr_pass;
          item.tag_first = 1'b1;
        end else begin
          item.out_byte = cmd_i.data;
          item.tag_last = cmd_i.last;
        end
      end
      OP_DATA: begin
        item.out_byte = cmd_i.data;
        item.tag_last = cmd_i.last;
      end
      OP_DATA_ERR: begin
        if (eff == 3'd0) begin
          item.out_byte = cmd_i.data;
        end else begin
          item.tag_last   = 1'b1;
          item.error_code = cmd_i.err;
        end
      end
      OP_FRAME: begin
        case (eff)
          3'd0: begin
            item.out_byte  = hdr_aac;
            item.tag_kind  = KIND_SEQ;
            item.tag_first = 1'b1;
          end
          3'd1: begin
            item.out_byte = PKT_SEQ_HDR;
            item.tag_kind = KIND_SEQ;
          end
          3'd2: begin
            item.out_byte = cmd_i.asc0;
            item.tag_kind = KIND_SEQ;
          end
          3'd3: begin
            item.out_byte = cmd_i.asc1;
            item.tag_kind = KIND_SEQ;
            item.tag_last = 1'b1;
          end
          3'd4: begin
            item.out_byte  = hdr_aac;
            item.tag_first = 1'b1;
          end
          default: begin
            item.out_byte = PKT_RAW;
            item.tag_last = cmd_i.last;
          end
        endcase
      end
      default: begin
        item.tag_kind   = KIND_RAW;
        item.tag_last   = 1'b1;
        item.error_code = cmd_i.err;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        idx_q       <= pop_o ? 3'd0 : idx_q + 3'd1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.error_code != ERR_NONE)) |->
      (out_q.tag_last && (out_q.out_byte == 8'h00) && (out_q.tag_kind == KIND_RAW)))
    else $error("error request is not a closing zero byte");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i |-> (eff <= end_idx))
    else $error("item index ran past the end of its command");
`endif

endmodule

// File: hw/rtl/adts_to_flv_audio_tag_repacker.sv
// ----------------------------------------------------------------------------
// ADTS to FLV audio tag repacker
// Parses a byte stream of AAC ADTS frames and emits FLV audio tag bodies,
// or passes bytes through behind one header byte for other formats.
// ----------------------------------------------------------------------------
// Channel   Handshake          Payload
// in        valid / stall      in_data_i  (data_byte, last_in_buffer)
// out       valid / stall      out_data_o (out_byte, tag_kind, tag_first,
//                                          tag_last, error_code)
// cfg       valid / ready      cfg_index_i, cfg_data_i
//
// The parser handles each input byte as it is accepted; the tag builder emits
// one byte per cycle while not stalled, so payload bytes flow at one per cycle.
// A completed header yields up to six output bytes; the four-entry command
// queue absorbs that burst and the input stalls only while the queue is full.
// The output register holds its request while out_stall_i is high.
// Reset is asynchronous and needs no clearing pass; configuration writes are
// always taken.
// ----------------------------------------------------------------------------
module adts_to_flv_audio_tag_repacker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  atfr_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output atfr_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [3:0]          cfg_data_i
);
  import atfr_pkg::*;

  cfg_t cfg_q;
  logic accept;
  logic full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic cmd_valid;
  cmd_t cmd;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign accept      = in_valid_i && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.format_code  <= FMT_AAC;
      cfg_q.rate_code    <= RATE_44100;
      cfg_q.sample_size  <= 1'b1;
      cfg_q.channel_mode <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FORMAT: cfg_q.format_code  <= cfg_data_i;
        CFG_RATE:   cfg_q.rate_code    <= cfg_data_i[1:0];
        CFG_SIZE:   cfg_q.sample_size  <= cfg_data_i[0];
        CFG_TYPE:   cfg_q.channel_mode <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  atfr_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .in_i     (in_data_i),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  atfr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (cmd_valid),
    .pop_data_o  (cmd)
  );

  atfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_data_o)
  );

endmodule

// File: tb/adts_to_flv_audio_tag_repacker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ADTS to FLV audio tag repacker testbench
// Streams AAC ADTS buffers and passthrough buffers into the repacker. A
// behavioral tag builder predicts every tag body byte and error, and a
// checker compares each output request with the oldest prediction.
// ----------------------------------------------------------------------------
module adts_to_flv_audio_tag_repacker_tb;
  import atfr_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef enum logic [1:0] {
    ST_BUF,
    ST_HDR,
    ST_PAY,
    ST_PASS
  } adts_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [3:0]  cfg_data_i;

  int          in_idle_pct;
  int          out_stall_pct;
  int          mismatches = 0;
  int          bytes_sent = 0;
  int unsigned cycle_cnt = 0;

  logic [7:0]  frame_q[$];
  out_item_t   tag_bytes_q[$];

  cfg_t        cfg_mirror;
  adts_phase_e adts_phase;
  logic [3:0]  hdr_idx;
  logic [1:0]  fr_profile;
  logic [3:0]  fr_sfi;
  logic [2:0]  fr_chan;
  logic        fr_crc;
  logic [12:0] fr_len;
  logic [12:0] pay_left;
  logic        seq_hdr_done;
  logic        drop_rest;

  adts_to_flv_audio_tag_repacker i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  // Tag builder model.

  function automatic logic [7:0] flv_hdr(logic [3:0] fmt);
    return {fmt, cfg_mirror.rate_code, cfg_mirror.sample_size, cfg_mirror.channel_mode};
  endfunction

  task automatic push_tag(logic [7:0] b, kind_e k, logic f, logic l, err_e e);
    tag_bytes_q.push_back('{out_byte: b, tag_kind: k, tag_first: f, tag_last: l,
                            error_code: e});
  endtask

  task automatic flag_error(err_e code, logic l);
    push_tag(8'h00, KIND_RAW, 1'b0, 1'b1, code);
    hdr_idx    = '0;
    adts_phase = ST_BUF;
    if (!l) drop_rest = 1'b1;
  endtask

  task automatic frame_done(logic l);
    hdr_idx    = '0;
    adts_phase = l ? ST_BUF : ST_HDR;
  endtask

  task automatic reset_model();
    cfg_mirror   = '{format_code: FMT_AAC, rate_code: RATE_44100, sample_size: 1'b1,
                     channel_mode: 1'b1};
    adts_phase   = ST_BUF;
    hdr_idx      = '0;
    fr_profile   = '0;
    fr_sfi       = '0;
    fr_chan      = '0;
    fr_crc       = 1'b0;
    fr_len       = '0;
    pay_left     = '0;
    seq_hdr_done = 1'b0;
    drop_rest    = 1'b0;
  endtask

  task automatic repack_byte(logic [7:0] b, logic l);
    logic [3:0]  hsize;
    logic [12:0] pl;
    logic [3:0]  sfi;
    logic [4:0]  obj;
    if (drop_rest) begin
      if (l) begin
        drop_rest  = 1'b0;
        adts_phase = ST_BUF;
        hdr_idx    = '0;
      end
      return;
    end
    if (adts_phase == ST_BUF) begin
      if (cfg_mirror.format_code != FMT_AAC) begin
        push_tag(flv_hdr(cfg_mirror.format_code), KIND_PASS, 1'b1, 1'b0, ERR_NONE);
        push_tag(b, KIND_PASS, 1'b0, l, ERR_NONE);
        adts_phase = l ? ST_BUF : ST_PASS;
        return;
      end
      adts_phase = ST_HDR;
      hdr_idx    = '0;
    end
    if (adts_phase == ST_PASS) begin
      push_tag(b, KIND_PASS, 1'b0, l, ERR_NONE);
      if (l) adts_phase = ST_BUF;
      return;
    end
    if (adts_phase == ST_PAY) begin
      pay_left = pay_left - 13'd1;
      if (pay_left == '0) begin
        push_tag(b, KIND_RAW, 1'b0, 1'b1, ERR_NONE);
        frame_done(l);
      end else begin
        push_tag(b, KIND_RAW, 1'b0, 1'b0, ERR_NONE);
        if (l) flag_error(ERR_TRUNC, l);
      end
      return;
    end
    case (hdr_idx)
      4'd0: begin
        if (b != SYNC_BYTE) begin
          flag_error(ERR_SYNC, l);
          return;
        end
      end
      4'd1: begin
        if (b[7:4] != SYNC_NIBBLE) begin
          flag_error(ERR_SYNC, l);
          return;
        end
        fr_crc = ~b[0];
      end
      4'd2: begin
        fr_profile = b[7:6];
        fr_sfi     = b[5:2];
        fr_chan    = {b[0], 2'b00};
      end
      4'd3: begin
        fr_chan[1:0] = b[7:6];
        fr_len       = {b[1:0], 11'd0};
      end
      4'd4: begin
        fr_len[10:3] = b;
        fr_len[2:0]  = 3'd0;
      end
      4'd5: fr_len[2:0] = b[7:5];
      default: ;
    endcase
    hsize = fr_crc ? HSIZE_CRC : HSIZE_NO_CRC;
    if (hdr_idx + 4'd1 < hsize) begin
      hdr_idx = hdr_idx + 4'd1;
      if (l) flag_error(ERR_TRUNC, l);
      return;
    end
    if (fr_len < {9'd0, hsize}) begin
      flag_error(ERR_TRUNC, l);
      return;
    end
    pl = fr_len - {9'd0, hsize};
    if (l && pl != '0) begin
      flag_error(ERR_TRUNC, l);
      return;
    end
    if (!seq_hdr_done) begin
      if (fr_profile == PROFILE_BAD) begin
        flag_error(ERR_CFG, l);
        return;
      end
      obj = {3'd0, fr_profile} + 5'd1;
      sfi = fr_sfi;
      case (cfg_mirror.rate_code)
        RATE_11025: sfi = SFI_11025;
        RATE_22050: sfi = SFI_22050;
        RATE_44100: sfi = SFI_44100;
        default: ;
      endcase
      if (sfi == SFI_BAD) begin
        flag_error(ERR_CFG, l);
        return;
      end
      push_tag(flv_hdr(FMT_AAC), KIND_SEQ, 1'b1, 1'b0, ERR_NONE);
      push_tag(PKT_SEQ_HDR, KIND_SEQ, 1'b0, 1'b0, ERR_NONE);
      push_tag({obj, sfi[3:1]}, KIND_SEQ, 1'b0, 1'b0, ERR_NONE);
      push_tag({sfi[0], 1'b0, fr_chan, 3'b000}, KIND_SEQ, 1'b0, 1'b1, ERR_NONE);
      seq_hdr_done = 1'b1;
    end
    push_tag(flv_hdr(FMT_AAC), KIND_RAW, 1'b1, 1'b0, ERR_NONE);
    push_tag(PKT_RAW, KIND_RAW, 1'b0, (pl == '0), ERR_NONE);
    if (pl == '0) begin
      frame_done(l);
    end else begin
      pay_left   = pl;
      hdr_idx    = '0;
      adts_phase = ST_PAY;
    end
  endtask

  // Output checker.

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (tag_bytes_q.size() == 0) begin
        $error("unexpected output request: %h", out_data_o);
        mismatches++;
      end else begin
        want = tag_bytes_q.pop_front();
        if (out_data_o.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_data_o.out_byte);
          mismatches++;
        end
        if (out_data_o.tag_kind !== want.tag_kind) begin
          $error("tag_kind: expected %0d, got %0d", want.tag_kind, out_data_o.tag_kind);
          mismatches++;
        end
        if (out_data_o.tag_first !== want.tag_first) begin
          $error("tag_first: expected %0b, got %0b", want.tag_first, out_data_o.tag_first);
          mismatches++;
        end
        if (out_data_o.tag_last !== want.tag_last) begin
          $error("tag_last: expected %0b, got %0b", want.tag_last, out_data_o.tag_last);
          mismatches++;
        end
        if (out_data_o.error_code !== want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code,
                 out_data_o.error_code);
          mismatches++;
        end
      end
    end
  end

  // Stimulus.

  task automatic send_byte(logic [7:0] b, logic l);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{data_byte: b, last_in_buffer: l};
    do @(posedge clk_i); while (in_stall_o);
    repack_byte(b, l);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_buf(logic ends);
    foreach (frame_q[i]) send_byte(frame_q[i], ends && (i == frame_q.size() - 1));
    frame_q.delete();
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (tag_bytes_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [3:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_FORMAT: cfg_mirror.format_code  = val;
      CFG_RATE:   cfg_mirror.rate_code    = val[1:0];
      CFG_SIZE:   cfg_mirror.sample_size  = val[0];
      CFG_TYPE:   cfg_mirror.channel_mode = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic randomize_cfg();
    write_reg(CFG_FORMAT, ($urandom_range(99) < 70) ? FMT_AAC : 4'($urandom_range(15)));
    write_reg(CFG_RATE, 4'($urandom));
    write_reg(CFG_SIZE, 4'($urandom));
    write_reg(CFG_TYPE, 4'($urandom));
  endtask

  task automatic add_adts(logic [1:0] prof, logic [3:0] sfi, logic [2:0] chan, logic crc,
                          logic [12:0] flen);
    frame_q.push_back(SYNC_BYTE);
    frame_q.push_back({SYNC_NIBBLE, 3'($urandom), ~crc});
    frame_q.push_back({prof, sfi, 1'($urandom), chan[2]});
    frame_q.push_back({chan[1:0], 4'($urandom), flen[12:11]});
    frame_q.push_back(flen[10:3]);
    frame_q.push_back({flen[2:0], 5'($urandom)});
    frame_q.push_back(8'($urandom));
    if (crc) repeat (2) frame_q.push_back(8'($urandom));
  endtask

  task automatic add_payload(int n);
    repeat (n) frame_q.push_back(8'($urandom));
  endtask

  task automatic add_good_frame();
    logic crc;
    int   pl;
    crc = 1'($urandom);
    pl  = ($urandom_range(19) == 0) ? $urandom_range(60) : $urandom_range(8);
    add_adts(2'($urandom), 4'($urandom), 3'($urandom), crc,
             13'((crc ? HSIZE_CRC : HSIZE_NO_CRC) + pl));
    add_payload(pl);
  endtask

  task automatic test_sync_errors();
    frame_q = '{8'h12, 8'h34};
    send_buf(1'b1);
    frame_q = '{SYNC_BYTE, 8'he1, 8'h55};
    send_buf(1'b1);
  endtask

  task automatic test_seq_header_checks();
    write_reg(CFG_RATE, RATE_5512);
    write_reg(CFG_SIZE, 4'd0);
    write_reg(CFG_TYPE, 4'd0);
    add_adts(PROFILE_BAD, 4'd4, 3'd2, 1'b0, 13'd7);
    send_buf(1'b1);
    add_adts(2'd1, SFI_BAD, 3'd1, 1'b0, 13'd7);
    send_buf(1'b1);
    add_adts(2'd1, 4'd3, 3'd7, 1'b1, 13'd9);
    add_adts(2'd0, 4'd8, 3'd2, 1'b0, 13'd10);
    frame_q.push_back(8'hff);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'ha5);
    send_buf(1'b1);
  endtask

  task automatic test_truncation();
    frame_q = '{SYNC_BYTE, 8'hf1, 8'h50};
    send_buf(1'b1);
    add_adts(2'd1, 4'd4, 3'd2, 1'b0, 13'd4);
    add_payload(2);
    send_buf(1'b1);
    add_adts(2'd1, 4'd4, 3'd2, 1'b0, 13'd11);
    send_buf(1'b1);
    add_adts(2'd2, 4'd4, 3'd2, 1'b0, 13'd12);
    add_payload(2);
    send_buf(1'b1);
  endtask

  task automatic test_passthrough();
    write_reg(CFG_FORMAT, 4'd0);
    write_reg(CFG_RATE, RATE_44100);
    write_reg(CFG_SIZE, 4'd1);
    write_reg(CFG_TYPE, 4'd1);
    frame_q = '{8'h00, 8'hff};
    send_buf(1'b1);
    write_reg(CFG_FORMAT, 4'd15);
    frame_q = '{8'h5a};
    send_buf(1'b1);
    write_reg(CFG_FORMAT, FMT_AAC);
  endtask

  // The format is latched at buffer start; a write in the middle of a buffer
  // only takes effect with the next buffer.
  task automatic test_format_switch();
    add_adts(2'd1, 4'd4, 3'd2, 1'b0, 13'd11);
    add_payload(2);
    send_buf(1'b0);
    drain();
    write_reg(CFG_FORMAT, 4'd3);
    add_payload(2);
    send_buf(1'b1);
    frame_q = '{8'haa, 8'h55};
    send_buf(1'b1);
    write_reg(CFG_FORMAT, FMT_AAC);
  endtask

  task automatic random_traffic(int n);
    int   start;
    int   pick;
    int   cut;
    logic crc;
    start = bytes_sent;
    while (bytes_sent - start < n) begin
      if ($urandom_range(99) < 12) randomize_cfg();
      pick = $urandom_range(99);
      crc  = 1'($urandom);
      if (cfg_mirror.format_code != FMT_AAC) begin
        add_payload($urandom_range(1, 6));
      end else if (pick < 65) begin
        repeat ($urandom_range(1, 3)) add_good_frame();
      end else if (pick < 77) begin
        add_good_frame();
        add_good_frame();
        cut = $urandom_range(1, frame_q.size() - 1);
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end else if (pick < 85) begin
        add_payload($urandom_range(1, 4));
      end else if (pick < 93) begin
        add_adts(2'($urandom), 4'($urandom), 3'($urandom), crc,
                 13'($urandom_range(crc ? 8 : 6)));
        add_payload($urandom_range(3));
      end else begin
        add_adts(2'($urandom), 4'($urandom), 3'($urandom), crc,
                 13'($urandom_range(20, 8191)));
        add_payload($urandom_range(8));
      end
      send_buf(1'b1);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_FORMAT;
    cfg_data_i    = '0;
    in_idle_pct   = 36;
    out_stall_pct = 70;
    reset_model();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_sync_errors();
    test_seq_header_checks();
    test_truncation();
    test_passthrough();
    test_format_switch();

    random_traffic(30);
    drain();
    in_idle_pct   = 70;
    out_stall_pct = 36;
    randomize_cfg();
    random_traffic(30);
    drain();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    randomize_cfg();
    random_traffic(30);
    drain();

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
